@@ rtl/core/kmk_pkg.sv @@
// ----------------------------------------------------------------------------
// kmk_pkg
// Shared constants, key-code ROM and handshake structs of the keypad key FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package kmk_pkg;

  localparam int ROW_COUNT    = 18;
  localparam int COLUMN_COUNT = 8;
  localparam int RING_SLOTS   = 32;
  localparam int ROM_SIZE     = 144;

  localparam int ROW_W  = 5;
  localparam int COL_W  = $clog2(COLUMN_COUNT);
  localparam int CODE_W = 8;
  localparam int ROW_IW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam int PCNT_W = $clog2(COLUMN_COUNT + 1);
  localparam int CMP_W  = SLOT_W + PCNT_W;

  localparam logic [CODE_W-1:0] CODE_NONE = 8'hff;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_POP    = 1'b1
  } req_e;

  localparam logic [CODE_W-1:0] CODE_ROM [ROM_SIZE] = '{
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h12,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'h7a,8'h14,8'h61,8'h73,8'h11,8'hff,
    8'hff,8'h63,8'h78,8'h64,8'h71,8'h09,8'h31,8'hff,
    8'hff,8'h66,8'h65,8'h77,8'h32,8'h33,8'h70,8'h1b,
    8'h76,8'h67,8'h74,8'h72,8'h34,8'h35,8'h72,8'h71,
    8'hff,8'h68,8'h75,8'h79,8'h36,8'h37,8'h74,8'h73,
    8'hff,8'h6b,8'h6a,8'h69,8'h38,8'h39,8'h76,8'h75,
    8'hff,8'h6c,8'h70,8'h6f,8'h30,8'hff,8'h78,8'h77,
    8'h6d,8'h3b,8'h5b,8'hff,8'h2d,8'hff,8'h7a,8'h79,
    8'h62,8'h2c,8'h27,8'hff,8'hff,8'h3d,8'h90,8'h7b,
    8'hff,8'hff,8'h6e,8'h2e,8'hff,8'hff,8'h13,8'h2d,
    8'h20,8'h2f,8'hff,8'hff,8'h5d,8'hff,8'h25,8'h2a,
    8'h10,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h10,
    8'h27,8'h28,8'hff,8'h26,8'h0d,8'h5c,8'h08,8'h2e,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h11,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff
  };

  // positions past the table read as unused keys
  function automatic logic [CODE_W-1:0] rom_code(input logic [ROW_W+COL_W-1:0] idx);
    logic [CODE_W-1:0] code;
    code = CODE_NONE;
    if (idx < (ROW_W+COL_W)'(ROM_SIZE)) begin
      code = CODE_ROM[idx];
    end
    return code;
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : s + 1'b1;
    return n;
  endfunction

  typedef struct packed {
    logic                                 load;
    logic [COLUMN_COUNT-1:0]              keep;
    logic [COLUMN_COUNT-1:0][CODE_W-1:0]  codes;
    logic [PCNT_W-1:0]                    pushed;
  } push_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] count;
    logic              phys_empty;
    logic              busy;
  } ring_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/kmk_lane.sv @@
// ----------------------------------------------------------------------------
// kmk_lane
// One column lane: press detection and key-code lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module kmk_lane (
  input  logic [kmk_pkg::COL_W-1:0]  col_i,
  input  logic [kmk_pkg::ROW_W-1:0]  row_i,
  input  logic                       prev_i,
  input  logic                       level_i,
  output logic                       press_o,
  output logic [kmk_pkg::CODE_W-1:0] code_o
);
  import kmk_pkg::*;

  // released before, low now
  assign press_o = prev_i & ~level_i;
  assign code_o  = rom_code({row_i, col_i});

endmodule

`default_nettype wire

@@ rtl/core/kmk_merge.sv @@
// ----------------------------------------------------------------------------
// kmk_merge
// Merges lane presses: keeps what fits in the ring, flags drops.
// ----------------------------------------------------------------------------
`default_nettype none

module kmk_merge (
  input  logic [kmk_pkg::COLUMN_COUNT-1:0] press_i,
  input  logic [kmk_pkg::SLOT_W-1:0]       count_i,
  output logic [kmk_pkg::COLUMN_COUNT-1:0] keep_o,
  output logic [kmk_pkg::PCNT_W-1:0]       pushed_o,
  output logic                             dropped_o
);
  import kmk_pkg::*;

  logic [SLOT_W-1:0] free_slots;
  logic [PCNT_W-1:0] run;

  assign free_slots = SLOT_W'(RING_SLOTS - 1) - count_i;

  // lowest columns win the free slots
  always_comb begin
    run = '0;
    for (int i = 0; i < COLUMN_COUNT; i++) begin
      keep_o[i] = press_i[i] && (CMP_W'(run) < CMP_W'(free_slots));
      run = run + PCNT_W'(press_i[i]);
    end
  end

  assign dropped_o = CMP_W'(run) > CMP_W'(free_slots);
  assign pushed_o  = dropped_o ? PCNT_W'(free_slots) : run;

endmodule

`default_nettype wire

@@ rtl/core/kmk_ring.sv @@
// ----------------------------------------------------------------------------
// kmk_ring
// Key-code ring: pointers, one-code-per-cycle writer and registered pop read.
// ----------------------------------------------------------------------------
`default_nettype none

module kmk_ring (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kmk_pkg::push_req_t         push_i,
  input  logic                       pop_i,
  output kmk_pkg::ring_stat_t        stat_o,
  output logic [kmk_pkg::CODE_W-1:0] rd_data_o
);
  import kmk_pkg::*;

  logic [CODE_W-1:0] mem [RING_SLOTS];

  // wl: write slot once queued codes land, wp: slot actually written
  logic [SLOT_W-1:0] wl_q, wl_d;
  logic [SLOT_W-1:0] wp_q, wp_d;
  logic [SLOT_W-1:0] rd_q, rd_d;
  logic [COLUMN_COUNT-1:0] pend_q, pend_d;
  logic [COLUMN_COUNT-1:0][CODE_W-1:0] codes_q;
  logic [CODE_W-1:0] rd_data_q;

  logic [COLUMN_COUNT-1:0] pend_rest;
  logic [COL_W-1:0]        wsel;
  logic                    wr_en;
  logic [SLOT_W-1:0]       wp_next;
  logic [SLOT_W-1:0]       rd_next;
  logic [SLOT_W:0]         diff;
  logic [SLOT_W:0]         wsum;
  logic [SLOT_W:0]         gap;

  assign pend_rest = pend_q & (pend_q - 1'b1);
  assign wr_en     = |pend_q;
  assign wp_next   = next_slot(wp_q);
  assign rd_next   = next_slot(rd_q);

  always_comb begin
    wsel = '0;
    for (int i = COLUMN_COUNT - 1; i >= 0; i--) begin
      if (pend_q[i]) wsel = COL_W'(i);
    end
  end

  always_comb begin
    diff = {1'b0, wl_q} - {1'b0, rd_q};
    if (wl_q < rd_q) diff = diff + (SLOT_W+1)'(RING_SLOTS);
  end

  always_comb begin
    gap = {1'b0, wl_q} - {1'b0, wp_q};
    if (wl_q < wp_q) gap = gap + (SLOT_W+1)'(RING_SLOTS);
  end

  always_comb begin
    wsum = {1'b0, wl_q} + (SLOT_W+1)'(push_i.pushed);
    if (wsum >= (SLOT_W+1)'(RING_SLOTS)) wsum = wsum - (SLOT_W+1)'(RING_SLOTS);
  end

  always_comb begin
    wl_d   = push_i.load ? SLOT_W'(wsum) : wl_q;
    wp_d   = wr_en ? wp_next : wp_q;
    rd_d   = pop_i ? rd_next : rd_q;
    pend_d = push_i.load ? push_i.keep : pend_rest;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= '0;
      wp_q   <= '0;
      rd_q   <= '0;
      pend_q <= '0;
    end else begin
      wl_q   <= wl_d;
      wp_q   <= wp_d;
      rd_q   <= rd_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.load) begin
      codes_q <= push_i.codes;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_next] <= codes_q[wsel];
    end
    if (pop_i) begin
      rd_data_q <= mem[rd_next];
    end
  end

  assign stat_o.count      = SLOT_W'(diff);
  assign stat_o.phys_empty = (wp_q == rd_q);
  assign stat_o.busy       = |pend_rest;
  assign rd_data_o         = rd_data_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.load |-> !(|pend_rest))
    else $error("new codes loaded over pending writes");

  a_pop_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (wp_q != rd_q))
    else $error("pop reads a slot not yet written");

  a_pending_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pend_q) == int'(gap))
    else $error("pending codes do not match pointer gap");

  a_writer_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !push_i.load) |=> ($countones(pend_q) == $countones($past(pend_q)) - 1))
    else $error("writer did not retire one code");

endmodule

`default_nettype wire

@@ rtl/core/keypad_matrix_change_to_key_fifo.sv @@
// ----------------------------------------------------------------------------
// keypad_matrix_change_to_key_fifo
// Throughput: one request per cycle while stage A can move; a sample queuing
//   k codes holds the next sample while more than one of them is still to be
//   written (the ring writes one code a cycle), and a pop waits until the first queued code has been written.
// Reset: asynchronous, active low; all rows read released, ring empty, no
//   result pending. Ring contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_matrix_change_to_key_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [kmk_pkg::ROW_W-1:0]  row_index_i,
  input  logic [7:0]                 row_bits_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       char_valid_o,
  output logic [kmk_pkg::CODE_W-1:0] char_code_o,
  output logic                       queue_nonempty_o,
  output logic                       keys_dropped_o
);
  import kmk_pkg::*;

  // Last sample of every row; reset reads all keys released.
  logic [COLUMN_COUNT-1:0] prev_q [ROW_COUNT];

  logic              is_pop, is_sample, row_ok, accept;
  logic [ROW_IW-1:0] row_sel;
  logic [COLUMN_COUNT-1:0] prev_row;

  // lane results
  logic [COLUMN_COUNT-1:0]             press, press_ok;
  logic [COLUMN_COUNT-1:0][CODE_W-1:0] lane_code;

  // merge results
  logic [COLUMN_COUNT-1:0] keep;
  logic [PCNT_W-1:0]       pushed;
  logic                    dropped;

  push_req_t  push_req;
  ring_stat_t rstat;
  logic       pop_go;
  logic [CODE_W-1:0] rd_data;

  // Stage A holds the result while the ring read settles; stage B is the
  // output register. A new request enters while B waits only if A is empty.
  logic a_valid_q, a_valid_d;
  logic a_pop_q, a_nonempty_q, a_dropped_q;
  logic a_adv, a_free;

  logic out_valid_q, out_valid_d;
  logic char_valid_q, nonempty_q, dropped_q;
  logic [CODE_W-1:0] char_code_q;

  assign is_pop    = (req_type_i == REQ_POP);
  assign is_sample = (req_type_i == REQ_SAMPLE);
  assign row_ok    = ({1'b0, row_index_i} < (ROW_W+1)'(ROW_COUNT));
  assign row_sel   = row_index_i[ROW_IW-1:0];
  assign prev_row  = row_ok ? prev_q[row_sel] : '1;

  assign a_adv  = a_valid_q && (!out_valid_q || !out_stall_i);
  assign a_free = !a_valid_q || a_adv;

  // Stall on a full pipe, on a sample while the writer still has more than
  // one code to place, and on a pop whose code is not yet in memory.
  assign in_stall_o = !a_free
                    || (is_sample && rstat.busy)
                    || (is_pop && (rstat.count != '0) && rstat.phys_empty);
  assign accept = in_valid_i && !in_stall_o;

  // One lane per column
  for (genvar c = 0; c < COLUMN_COUNT; c++) begin : g_lane
    kmk_lane u_lane (
      .col_i   (COL_W'(c)),
      .row_i   (row_index_i),
      .prev_i  (prev_row[c]),
      .level_i (row_bits_i[c]),
      .press_o (press[c]),
      .code_o  (lane_code[c])
    );
  end

  // out-of-range rows never push anything
  assign press_ok = press & {COLUMN_COUNT{row_ok}};

  kmk_merge u_merge (
    .press_i   (press_ok),
    .count_i   (rstat.count),
    .keep_o    (keep),
    .pushed_o  (pushed),
    .dropped_o (dropped)
  );

  assign push_req.load   = accept && is_sample && row_ok;
  assign push_req.keep   = keep;
  assign push_req.codes  = lane_code;
  assign push_req.pushed = pushed;

  assign pop_go = accept && is_pop && (rstat.count != '0);

  kmk_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_req),
    .pop_i     (pop_go),
    .stat_o    (rstat),
    .rd_data_o (rd_data)
  );

  // previous-row store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        prev_q[r] <= '1;
      end
    end else if (push_req.load) begin
      prev_q[row_sel] <= row_bits_i;
    end
  end

  // stage A
  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pop_q <= pop_go;
      if (is_pop) begin
        a_nonempty_q <= (rstat.count > SLOT_W'(1));
        a_dropped_q  <= 1'b0;
      end else begin
        a_nonempty_q <= (rstat.count != '0) || (pushed != '0);
        a_dropped_q  <= dropped;
      end
    end
  end

  // stage B, output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (a_adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      char_valid_q <= a_pop_q;
      char_code_q  <= a_pop_q ? rd_data : '0;
      nonempty_q   <= a_nonempty_q;
      dropped_q    <= a_dropped_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign char_valid_o     = char_valid_q;
  assign char_code_o      = char_code_q;
  assign queue_nonempty_o = nonempty_q;
  assign keys_dropped_o   = dropped_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> a_free)
    else $error("request taken while stage A cannot move");

  a_pop_not_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(char_valid_o && keys_dropped_o))
    else $error("pop result flags a dropped key");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_go) |=> (a_valid_q && a_pop_q))
    else $error("pop did not reach stage A");

endmodule

`default_nettype wire

@@ dv/keypad_matrix_change_to_key_fifo_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_matrix_change_to_key_fifo_tb
// Drives row samples and pop requests into the keypad key FIFO, predicts
// every result with an independent scanner/ring model and checks each one.
// ----------------------------------------------------------------------------

module keypad_matrix_change_to_key_fifo_tb;

  import kmk_pkg::*;

  localparam int KEY_ROWS     = 18;
  localparam int KEY_COLS     = 8;
  localparam int RING_DEPTH   = 32;
  localparam int KEYMAP_SIZE  = 144;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_PCT     = 6;
  // no idling on either side while the count sits in this window
  localparam int CALM_LO      = 900;
  localparam int CALM_HI      = 1200;
  // long receiver hold-off, fills the block and backs up the request side
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_MAX = 2000;

  // key-code map, row*8+column
  localparam logic [7:0] KEYMAP [KEYMAP_SIZE] = '{
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h12,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'h7a,8'h14,8'h61,8'h73,8'h11,8'hff,8'hff,8'h63,8'h78,8'h64,8'h71,8'h09,8'h31,8'hff,
    8'hff,8'h66,8'h65,8'h77,8'h32,8'h33,8'h70,8'h1b,8'h76,8'h67,8'h74,8'h72,8'h34,8'h35,8'h72,8'h71,
    8'hff,8'h68,8'h75,8'h79,8'h36,8'h37,8'h74,8'h73,8'hff,8'h6b,8'h6a,8'h69,8'h38,8'h39,8'h76,8'h75,
    8'hff,8'h6c,8'h70,8'h6f,8'h30,8'hff,8'h78,8'h77,8'h6d,8'h3b,8'h5b,8'hff,8'h2d,8'hff,8'h7a,8'h79,
    8'h62,8'h2c,8'h27,8'hff,8'hff,8'h3d,8'h90,8'h7b,8'hff,8'hff,8'h6e,8'h2e,8'hff,8'hff,8'h13,8'h2d,
    8'h20,8'h2f,8'hff,8'hff,8'h5d,8'hff,8'h25,8'h2a,8'h10,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h10,
    8'h27,8'h28,8'hff,8'h26,8'h0d,8'h5c,8'h08,8'h2e,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h11,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff
  };

  typedef struct packed {
    req_e             kind;
    logic [ROW_W-1:0] row;
    logic [7:0]       bits;
  } key_req_t;

  typedef struct packed {
    logic             char_valid;
    logic [7:0]       char_code;
    logic             queue_nonempty;
    logic             keys_dropped;
  } key_result_t;

  // DUT hookup, every input known from time zero
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i     = 1'b0;
  logic [ROW_W-1:0]     row_index_i    = '0;
  logic [7:0]           row_bits_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic                 char_valid_o;
  logic [CODE_W-1:0]    char_code_o;
  logic                 queue_nonempty_o;
  logic                 keys_dropped_o;

  keypad_matrix_change_to_key_fifo dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .row_index_i      (row_index_i),
    .row_bits_i       (row_bits_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .char_valid_o     (char_valid_o),
    .char_code_o      (char_code_o),
    .queue_nonempty_o (queue_nonempty_o),
    .keys_dropped_o   (keys_dropped_o)
  );

  always #5 clk_i = ~clk_i;

  // requests waiting to go out, results waiting to come back
  key_req_t    pending_reqs[$];
  key_result_t expected_keys[$];

  // scanner model state
  logic [7:0]  last_rows [KEY_ROWS];
  logic [7:0]  code_ring [RING_DEPTH];
  int unsigned ring_wr;
  int unsigned ring_rd;

  int sent_count   = 0;
  int result_count = 0;
  int error_count  = 0;
  int idle_cycles  = 0;
  int hold_cycles  = 0;
  bit hold_done    = 1'b0;

  // one request in, one result out
  task automatic predict_key_step(input key_req_t rq);
    key_result_t res;
    logic [7:0]  pressed;
    int unsigned nxt;
    int          idx;
    res = '0;
    if (rq.kind == REQ_POP) begin
      if (ring_wr != ring_rd) begin
        ring_rd        = (ring_rd + 1) % RING_DEPTH;
        res.char_valid = 1'b1;
        res.char_code  = code_ring[ring_rd];
      end
    end else if (int'(rq.row) < KEY_ROWS) begin
      // changed and now low = fresh press
      pressed = (last_rows[rq.row] ^ rq.bits) & ~rq.bits;
      for (int col = 0; col < KEY_COLS; col++) begin
        if (pressed[col]) begin
          nxt = (ring_wr + 1) % RING_DEPTH;
          if (nxt == ring_rd) begin
            res.keys_dropped = 1'b1;   // ring full, keep trying later columns
          end else begin
            idx              = int'(rq.row) * KEY_COLS + col;
            ring_wr          = nxt;
            code_ring[ring_wr] = (idx < KEYMAP_SIZE) ? KEYMAP[idx] : 8'hff;
          end
        end
      end
      last_rows[rq.row] = rq.bits;
    end
    // out-of-range rows fall through untouched
    res.queue_nonempty = (ring_wr != ring_rd);
    expected_keys.push_back(res);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // request driver: hold payload while stalled, random gaps between requests
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    key_req_t nxt;
    bit       calm;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      req_type_i  <= REQ_SAMPLE;
      row_index_i <= '0;
      row_bits_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        nxt.kind = req_e'(req_type_i);
        nxt.row  = row_index_i;
        nxt.bits = row_bits_i;
        predict_key_step(nxt);
        sent_count <= sent_count + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        calm = (sent_count >= CALM_LO) && (sent_count < CALM_HI);
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt         = pending_reqs.pop_front();
          in_valid_i  <= 1'b1;
          req_type_i  <= nxt.kind;
          row_index_i <= nxt.row;
          row_bits_i  <= nxt.bits;
        end else begin
          in_valid_i  <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    key_result_t want;
    bit          calm;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        result_count <= result_count + 1;
        if (expected_keys.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_keys.pop_front();
          check_field("char_valid", 8'(want.char_valid), 8'(char_valid_o));
          check_field("char_code", want.char_code, char_code_o);
          check_field("queue_nonempty", 8'(want.queue_nonempty), 8'(queue_nonempty_o));
          check_field("keys_dropped", 8'(want.keys_dropped), 8'(keys_dropped_o));
        end
      end
      calm = (result_count >= CALM_LO) && (result_count < CALM_HI);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && result_count >= HOLD_AT) begin
        hold_done   <= 1'b1;
        hold_cycles <= HOLD_LEN;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_req(input req_e kind, input int row, input int bits);
    key_req_t rq;
    rq.kind = kind;
    rq.row  = ROW_W'(row);
    rq.bits = 8'(bits);
    pending_reqs.push_back(rq);
  endtask

  initial begin
    logic [7:0] gen_rows [KEY_ROWS];
    int         gen_count;
    int         pop_pct;
    int         burst;
    int         pick;
    int         row;
    logic [7:0] bits;

    for (int r = 0; r < KEY_ROWS; r++) begin
      last_rows[r] = 8'hff;
    end
    for (int s = 0; s < RING_DEPTH; s++) begin
      code_ring[s] = 8'h00;
    end
    ring_wr = 0;
    ring_rd = 0;

    // directed: empty pop, full rows, ignored rows, partial change, overflow
    queue_req(REQ_POP, 0, 0);              // pop with nothing queued
    queue_req(REQ_SAMPLE, 0, 8'h00);       // whole row 0 down, mostly unused codes
    queue_req(REQ_SAMPLE, 17, 8'h00);      // last row, all unused codes
    queue_req(REQ_SAMPLE, 18, 8'h00);      // first row past the matrix
    queue_req(REQ_SAMPLE, 31, 8'h00);      // top of the row field
    queue_req(REQ_SAMPLE, 1, 8'h00);
    queue_req(REQ_SAMPLE, 2, 8'h55);       // odd columns down
    queue_req(REQ_SAMPLE, 3, 8'h00);       // ring fills mid-row, rest dropped
    queue_req(REQ_SAMPLE, 4, 8'hfe);       // single press into a full ring
    queue_req(REQ_POP, 31, 8'hff);         // row fields ignored on a pop
    queue_req(REQ_POP, 0, 8'h00);
    queue_req(REQ_SAMPLE, 2, 8'h00);       // only even columns changed
    queue_req(REQ_SAMPLE, 0, 8'hff);       // release, no press
    queue_req(REQ_SAMPLE, 0, 8'h00);       // re-press, all dropped (ring full)
    queue_req(REQ_SAMPLE, 0, 8'h00);       // no change
    for (int i = 0; i < 6; i++) begin
      queue_req(REQ_POP, 0, 0);
    end
    for (int r = 0; r < KEY_ROWS; r++) begin
      gen_rows[r] = 8'hff;
    end
    gen_rows[0] = 8'h00;
    gen_rows[1] = 8'h00;
    gen_rows[2] = 8'h00;
    gen_rows[3] = 8'h00;
    gen_rows[4] = 8'hfe;
    gen_rows[17] = 8'h00;

    // random: bursts with a varying pop share so the ring fills and drains
    gen_count = 0;
    while (gen_count < RANDOM_ITEMS) begin
      pop_pct = $urandom_range(70, 10);
      burst   = $urandom_range(60, 20);
      repeat (burst) begin
        pick = $urandom_range(99);
        if ($urandom_range(99) < pop_pct) begin
          queue_req(REQ_POP, $urandom_range(31), $urandom_range(255));
          gen_count++;
        end else if (pick < 8) begin
          queue_req(REQ_SAMPLE, $urandom_range(31, KEY_ROWS), $urandom_range(255));
          gen_count++;
        end else begin
          row = $urandom_range(KEY_ROWS - 1);
          if (pick < 60) begin
            // typical scan: up to two keys move
            bits = gen_rows[row] ^ (8'h01 << $urandom_range(7));
            if (pick < 25) bits = bits ^ (8'h01 << $urandom_range(7));
          end else if (pick < 85) begin
            bits = 8'($urandom_range(255));
          end else begin
            bits = pick[0] ? 8'h00 : 8'hff;
          end
          gen_rows[row] = bits;
          queue_req(REQ_SAMPLE, row, bits);
          gen_count++;
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample on the falling edge, clear of the clocked processes
    @(negedge clk_i);
    while ((pending_reqs.size() > 0 || in_valid_i || expected_keys.size() > 0) &&
           idle_cycles < WATCHDOG_MAX) begin
      @(negedge clk_i);
    end

    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Some tests failed");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk_i);
      if (error_count == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
    end
    $finish;
  end

endmodule
